// ===== src/lz_block_compressor_assert.svh =====
// Assertion macros used by the compressor top level
`ifndef LZ_BLOCK_COMPRESSOR_ASSERT_SVH
`define LZ_BLOCK_COMPRESSOR_ASSERT_SVH

// a holds at an edge, b holds at the same edge
`define LZC_ASSERT_SAME(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lzc assertion failed");

// a holds at an edge, b holds at the next edge
`define LZC_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lzc assertion failed");

`endif

// ===== src/lzc_pkg.sv =====
// Shared types, constants and helper functions of the LZ block compressor
package lzc_pkg;

    localparam int SRC_BYTES = 8192;
    localparam int SRC_AW    = $clog2(SRC_BYTES);
    localparam int CNT_W     = SRC_AW + 1;
    localparam int OUT_BYTES = 16384;
    localparam int OUT_AW    = $clog2(OUT_BYTES);
    localparam int OLEN_W    = OUT_AW + 1;
    localparam int LOOKBACK  = 4096;
    localparam int MATCH_W   = 7;
    localparam int RUN_W     = 8;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic [MATCH_W-1:0] MIN_MATCH  = 7'd3;
    localparam logic [MATCH_W-1:0] STOP_MATCH = 7'd64;
    localparam logic [RUN_W-1:0]   MAX_RUN    = 8'd255;

    localparam logic [7:0] MAGIC0   = 8'hCE;
    localparam logic [7:0] MAGIC1   = 8'hB2;
    localparam logic [7:0] MAGIC2   = 8'hCF;
    localparam logic [7:0] MAGIC3   = 8'h81;
    localparam logic [7:0] TOK_LIT   = 8'd0;
    localparam logic [7:0] TOK_MATCH = 8'd1;
    localparam logic [7:0] TOK_END   = 8'd2;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_READ = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FAIL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [1:0] REG_QUALITY  = 2'd0;
    localparam logic [1:0] REG_CAPACITY = 2'd1;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       last;
    } item_t;

    function automatic logic [MATCH_W-1:0] len_limit(input logic [3:0] q);
        logic [MATCH_W-1:0] m;
        if (q < 4'd5)
            m = 7'd16;
        else if (q < 4'd8)
            m = 7'd32;
        else
            m = 7'd64;
        return m;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [2:0] k, input logic [3:0] q);
        logic [7:0] b;
        case (k)
            3'd0: b = MAGIC0;
            3'd1: b = MAGIC1;
            3'd2: b = MAGIC2;
            3'd3: b = MAGIC3;
            default:
            begin
                if (q < 4'd5)
                    b = 8'd10;
                else if (q < 4'd8)
                    b = 8'd22;
                else
                    b = 8'd24;
            end
        endcase
        return b;
    endfunction

endpackage

// ===== src/lzc_front.sv =====
// Input queue: accept beats and hold them for the compression engine
module lzc_front
    import lzc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  item_t      in_item,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    item_t             slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wp_reg;
    logic [Q_AW-1:0]   rp_reg;
    logic [Q_AW:0]     cnt_reg;
    logic              push;
    logic              pop;

    assign in_ready = (cnt_reg != Q_DEPTH[Q_AW:0]);
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = slot_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== src/lzc_engine.sv =====
// Back end: source and output stores, greedy match search, token writer and stream read-back
module lzc_engine
    import lzc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  quality,
    input  logic [14:0] out_capacity,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  res_byte,
    output logic        res_last,
    output logic [1:0]  res_status
);

    typedef enum logic [17:0] {
        ST_IDLE    = 18'd1 << 0,
        ST_RD_WAIT = 18'd1 << 1,
        ST_PRE     = 18'd1 << 2,
        ST_FAIL    = 18'd1 << 3,
        ST_HDR     = 18'd1 << 4,
        ST_TOP     = 18'd1 << 5,
        ST_SETUP   = 18'd1 << 6,
        ST_ISSUE   = 18'd1 << 7,
        ST_WAIT    = 18'd1 << 8,
        ST_NEXTC   = 18'd1 << 9,
        ST_DECIDE  = 18'd1 << 10,
        ST_EMITM   = 18'd1 << 11,
        ST_LITCHK  = 18'd1 << 12,
        ST_LITOUT  = 18'd1 << 13,
        ST_LITH1   = 18'd1 << 14,
        ST_COPY_RD = 18'd1 << 15,
        ST_COPY_WR = 18'd1 << 16,
        ST_ENDM    = 18'd1 << 17
    } state_t;

    logic [7:0]          src_mem [SRC_BYTES];
    logic [7:0]          out_mem [OUT_BYTES];

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                err_reg;
    logic [OLEN_W-1:0]   olen_reg;
    logic [OLEN_W-1:0]   rp_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    sp_reg;
    logic [OLEN_W-1:0]   d_reg;
    logic [CNT_W-1:0]    i_reg;
    logic [MATCH_W-1:0]  len_reg;
    logic [MATCH_W-1:0]  best_reg;
    logic [CNT_W-1:0]    bpos_reg;
    logic                lit_reg;
    logic [CNT_W-1:0]    start_reg;
    logic [RUN_W-1:0]    run_reg;
    logic [RUN_W-1:0]    k_reg;
    logic [MATCH_W-1:0]  maxlen_reg;
    logic [OLEN_W-1:0]   cap_reg;
    logic [3:0]          qual_reg;
    logic                mv_reg;
    logic [7:0]          mb_reg;
    logic                ml_reg;
    logic [1:0]          ms_reg;

    logic [7:0]          src_a_q;
    logic [7:0]          src_b_q;
    logic [7:0]          out_q;

    logic                src_we;
    logic [SRC_AW-1:0]   src_waddr;
    logic [CNT_W-1:0]    addr_a;
    logic [CNT_W-1:0]    addr_b;
    logic                o_we;
    logic [7:0]          o_wdata;
    logic [15:0]         d_ext;
    logic [15:0]         cap_ext;
    logic                lit_fail;
    logic                end_fail;
    logic [CNT_W-1:0]    match_dist;
    logic [CNT_W-1:0]    lo;
    logic                take;
    logic                err_new;
    logic [CNT_W-1:0]    cnt_new;

    assign take      = q_valid && q_ready;
    assign q_ready   = (state_reg == ST_IDLE) && !(q_item.op == OP_READ && mv_reg);
    assign res_valid = mv_reg;
    assign res_byte  = mb_reg;
    assign res_last  = ml_reg;
    assign res_status = ms_reg;

    assign d_ext      = {1'b0, d_reg};
    assign cap_ext    = {1'b0, cap_reg};
    assign lit_fail   = (d_ext + {8'd0, run_reg} + 16'd2) > cap_ext;
    assign end_fail   = (d_ext + 16'd1) > cap_ext;
    assign match_dist = sp_reg - bpos_reg;
    assign lo         = (sp_reg > CNT_W'(LOOKBACK)) ? sp_reg - CNT_W'(LOOKBACK) : '0;
    assign err_new    = ((cnt_reg == '0) ? 1'b0 : err_reg) | (cnt_reg == CNT_W'(SRC_BYTES));
    assign cnt_new    = (cnt_reg < CNT_W'(SRC_BYTES)) ? cnt_reg + 1'b1 : cnt_reg;

    assign src_we    = (state_reg == ST_IDLE) && take && (q_item.op == OP_LOAD)
                       && (cnt_reg < CNT_W'(SRC_BYTES));
    assign src_waddr = cnt_reg[SRC_AW-1:0];
    assign addr_a    = (state_reg == ST_COPY_RD) ? start_reg + {6'd0, k_reg}
                                                 : i_reg + {7'd0, len_reg};
    assign addr_b    = sp_reg + {7'd0, len_reg};

    always_comb
    begin
        o_we    = 1'b0;
        o_wdata = TOK_LIT;
        case (state_reg)
            ST_HDR:
            begin
                o_we    = 1'b1;
                o_wdata = hdr_byte(d_reg[2:0], qual_reg);
            end
            ST_EMITM:
            begin
                o_we = 1'b1;
                case (k_reg[1:0])
                    2'd0:    o_wdata = TOK_MATCH;
                    2'd1:    o_wdata = match_dist[7:0];
                    2'd2:    o_wdata = {2'd0, match_dist[CNT_W-1:8]};
                    default: o_wdata = {1'b0, best_reg};
                endcase
            end
            ST_LITOUT:
            begin
                o_we    = !lit_fail;
                o_wdata = TOK_LIT;
            end
            ST_LITH1:
            begin
                o_we    = 1'b1;
                o_wdata = run_reg;
            end
            ST_COPY_WR:
            begin
                o_we    = 1'b1;
                o_wdata = src_a_q;
            end
            ST_ENDM:
            begin
                o_we    = !end_fail;
                o_wdata = TOK_END;
            end
            default:
            begin
                o_we    = 1'b0;
                o_wdata = TOK_LIT;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
            src_mem[src_waddr] <= q_item.data;
        src_a_q <= src_mem[addr_a[SRC_AW-1:0]];
        src_b_q <= src_mem[addr_b[SRC_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (o_we)
            out_mem[d_reg[OUT_AW-1:0]] <= o_wdata;
        out_q <= out_mem[rp_reg[OUT_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            err_reg    <= 1'b0;
            olen_reg   <= '0;
            rp_reg     <= '0;
            n_reg      <= '0;
            sp_reg     <= '0;
            d_reg      <= '0;
            i_reg      <= '0;
            len_reg    <= '0;
            best_reg   <= '0;
            bpos_reg   <= '0;
            lit_reg    <= 1'b0;
            start_reg  <= '0;
            run_reg    <= '0;
            k_reg      <= '0;
            maxlen_reg <= '0;
            cap_reg    <= '0;
            qual_reg   <= '0;
            mv_reg     <= 1'b0;
            mb_reg     <= '0;
            ml_reg     <= 1'b0;
            ms_reg     <= STAT_OK;
        end
        else
        begin
            if (mv_reg && res_ready)
                mv_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (take && q_item.op == OP_READ)
                    begin
                        mb_reg <= '0;
                        ml_reg <= 1'b0;
                        if (err_reg)
                        begin
                            ms_reg <= STAT_FAIL;
                            mv_reg <= 1'b1;
                        end
                        else if (rp_reg < olen_reg)
                        begin
                            ms_reg    <= STAT_OK;
                            ml_reg    <= (rp_reg + 1'b1 == olen_reg);
                            rp_reg    <= rp_reg + 1'b1;
                            state_reg <= ST_RD_WAIT;
                        end
                        else
                        begin
                            ms_reg <= STAT_EMPTY;
                            mv_reg <= 1'b1;
                        end
                    end
                    else if (take)
                    begin
                        if (!q_item.last)
                        begin
                            if (cnt_reg == '0)
                            begin
                                olen_reg <= '0;
                                rp_reg   <= '0;
                            end
                            cnt_reg <= cnt_new;
                            err_reg <= err_new;
                        end
                        else
                        begin
                            cnt_reg    <= '0;
                            rp_reg     <= '0;
                            olen_reg   <= '0;
                            err_reg    <= 1'b1;
                            n_reg      <= cnt_new;
                            qual_reg   <= quality;
                            maxlen_reg <= len_limit(quality);
                            cap_reg    <= (out_capacity > OLEN_W'(OUT_BYTES))
                                          ? OLEN_W'(OUT_BYTES) : out_capacity;
                            if (!err_new)
                                state_reg <= ST_PRE;
                        end
                    end
                end
                ST_RD_WAIT:
                begin
                    mb_reg    <= out_q;
                    mv_reg    <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_PRE:
                begin
                    d_reg <= '0;
                    if (cap_reg < {1'b0, n_reg} || cap_reg < OLEN_W'(5))
                        state_reg <= ST_FAIL;
                    else
                        state_reg <= ST_HDR;
                end
                ST_FAIL:
                begin
                    olen_reg  <= '0;
                    rp_reg    <= '0;
                    err_reg   <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_HDR:
                begin
                    d_reg <= d_reg + 1'b1;
                    if (d_reg == OLEN_W'(4))
                    begin
                        sp_reg    <= '0;
                        state_reg <= ST_TOP;
                    end
                end
                ST_TOP:
                begin
                    lit_reg <= 1'b0;
                    if (sp_reg >= n_reg)
                        state_reg <= ST_ENDM;
                    else if (d_ext + 16'd8 >= cap_ext)
                        state_reg <= ST_FAIL;
                    else
                        state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    i_reg    <= lo;
                    len_reg  <= '0;
                    best_reg <= '0;
                    bpos_reg <= '0;
                    if (sp_reg == '0)
                        state_reg <= ST_DECIDE;
                    else
                        state_reg <= ST_ISSUE;
                end
                ST_ISSUE:
                begin
                    if (addr_b < n_reg && len_reg < maxlen_reg)
                        state_reg <= ST_WAIT;
                    else
                        state_reg <= ST_NEXTC;
                end
                ST_WAIT:
                begin
                    if (src_a_q == src_b_q)
                    begin
                        len_reg   <= len_reg + 1'b1;
                        state_reg <= ST_ISSUE;
                    end
                    else
                        state_reg <= ST_NEXTC;
                end
                ST_NEXTC:
                begin
                    if (len_reg > best_reg)
                    begin
                        best_reg <= len_reg;
                        bpos_reg <= i_reg;
                    end
                    len_reg <= '0;
                    i_reg   <= i_reg + 1'b1;
                    if ((len_reg > best_reg && len_reg >= STOP_MATCH)
                        || (i_reg + 1'b1 == sp_reg))
                        state_reg <= ST_DECIDE;
                    else
                        state_reg <= ST_ISSUE;
                end
                ST_DECIDE:
                begin
                    k_reg <= '0;
                    if (!lit_reg)
                    begin
                        if (best_reg >= MIN_MATCH)
                            state_reg <= ST_EMITM;
                        else
                        begin
                            start_reg <= sp_reg;
                            run_reg   <= 8'd1;
                            sp_reg    <= sp_reg + 1'b1;
                            lit_reg   <= 1'b1;
                            state_reg <= ST_LITCHK;
                        end
                    end
                    else if (best_reg >= MIN_MATCH)
                        state_reg <= ST_LITOUT;
                    else
                    begin
                        sp_reg    <= sp_reg + 1'b1;
                        run_reg   <= run_reg + 1'b1;
                        state_reg <= ST_LITCHK;
                    end
                end
                ST_EMITM:
                begin
                    d_reg <= d_reg + 1'b1;
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 8'd3)
                    begin
                        sp_reg    <= sp_reg + {7'd0, best_reg};
                        state_reg <= ST_TOP;
                    end
                end
                ST_LITCHK:
                begin
                    if (sp_reg < n_reg && run_reg < MAX_RUN)
                        state_reg <= ST_SETUP;
                    else
                        state_reg <= ST_LITOUT;
                end
                ST_LITOUT:
                begin
                    if (lit_fail)
                        state_reg <= ST_FAIL;
                    else
                    begin
                        d_reg     <= d_reg + 1'b1;
                        state_reg <= ST_LITH1;
                    end
                end
                ST_LITH1:
                begin
                    d_reg     <= d_reg + 1'b1;
                    k_reg     <= '0;
                    state_reg <= ST_COPY_RD;
                end
                ST_COPY_RD:
                begin
                    state_reg <= ST_COPY_WR;
                end
                ST_COPY_WR:
                begin
                    d_reg <= d_reg + 1'b1;
                    k_reg <= k_reg + 1'b1;
                    if (k_reg + 1'b1 == run_reg)
                        state_reg <= ST_TOP;
                    else
                        state_reg <= ST_COPY_RD;
                end
                ST_ENDM:
                begin
                    if (end_fail)
                        state_reg <= ST_FAIL;
                    else
                    begin
                        olen_reg  <= d_reg + 1'b1;
                        rp_reg    <= '0;
                        err_reg   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/lz_block_compressor.sv =====
// LZ block compressor top level: configuration registers, input queue and engine
// Load beats store one source byte per cycle, while no pass runs, into an
// 8192-byte block; the beat marked last starts a greedy LZ77 pass over the
// block. For each source position every start in the 4096-byte window behind
// it is tried until a 64-byte match ends the search, comparing bytes through
// the dual-read source memory in an issue and a wait state; literal bytes are
// copied by a read and a write state, and token bytes are written one per cycle.
// Beats stay queued (four deep) while a pass runs. A read beat returns a fail or
// empty status at the edge it leaves the queue, or a stream byte in the cycle
// after; a read between the loads of a block returns empty, or fail on overflow.
`include "lz_block_compressor_assert.svh"
module lz_block_compressor
    import lzc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    logic [3:0]  quality_reg;
    logic [14:0] capacity_reg;
    item_t       in_item;
    item_t       q_item;
    logic        q_valid;
    logic        q_ready;

    assign in_item.op   = s_tuser;
    assign in_item.data = s_tdata;
    assign in_item.last = s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quality_reg  <= 4'd5;
            capacity_reg <= 15'd16384;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUALITY:  quality_reg  <= cfg_data[3:0];
                REG_CAPACITY: capacity_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    lzc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    lzc_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .quality      (quality_reg),
        .out_capacity (capacity_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_byte     (m_tdata),
        .res_last     (m_tlast),
        .res_status   (m_tuser)
    );

    `LZC_ASSERT_SAME(a_fail_zero, m_tvalid && m_tuser != STAT_OK, m_tdata == 8'd0 && !m_tlast)
    `LZC_ASSERT_SAME(a_last_ok, m_tvalid && m_tlast, m_tuser == STAT_OK)
    `LZC_ASSERT_NEXT(a_cfg_cap, cfg_we && cfg_index == REG_CAPACITY, capacity_reg == $past(cfg_data))

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the LZ block compressor: table-driven directed beats, then random blocks
module tb_top;
    import lzc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;
    logic        s_tuser;   // [0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic        m_tlast;
    logic [1:0]  m_tuser;   // [1:0] status
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    lz_block_compressor dut (.*);

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } rd_beat_t;

    typedef struct {
        bit       fixed;
        rd_beat_t beat;
    } typed_t;

    typedef struct {
        bit         is_cfg;
        logic [1:0] idx;
        logic [14:0] val;
        logic       op;
        logic [7:0] data;
        logic       last;
        bit         fixed;
        rd_beat_t   beat;
    } row_t;

    // compressor state mirror
    logic [7:0]  src_mem [SRC_BYTES];
    logic [7:0]  strm_mem [OUT_BYTES];
    int unsigned src_cnt;
    int unsigned strm_len;
    int unsigned rd_ptr;
    bit          failed;
    logic [3:0]  quality;
    logic [14:0] capacity;

    rd_beat_t read_q[$];
    typed_t   typed_q[$];
    row_t     rows[$];
    int       errors;
    bit       calm;
    bit       hold_req;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial
    begin
        #500000000;
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned longest_run(input int unsigned p, input int unsigned n,
                                                input int unsigned maxlen,
                                                output int unsigned back_dist);
        int unsigned best;
        int unsigned best_at;
        int unsigned i;
        int unsigned len;
        best = 0;
        best_at = 0;
        back_dist = 0;
        i = (p > LOOKBACK) ? p - LOOKBACK : 0;
        for (; i < p; i++)
        begin
            len = 0;
            while (p + len < n && len < maxlen && src_mem[i + len] == src_mem[p + len])
                len++;
            if (len > best)
            begin
                best = len;
                best_at = i;
                if (best >= 64)
                    break;
            end
        end
        if (best < 3)
            return 0;
        back_dist = p - best_at;
        return best;
    endfunction

    function automatic int unsigned pack_block(input int unsigned n);
        int unsigned cap;
        int unsigned maxlen;
        int unsigned d;
        int unsigned sp;
        int unsigned back_dist;
        int unsigned mlen;
        int unsigned start;
        int unsigned run;
        cap = (capacity < OUT_BYTES) ? capacity : OUT_BYTES;
        maxlen = (quality < 5) ? 16 : ((quality < 8) ? 32 : 64);
        if (n == 0 || cap < n || cap < 5)
            return 0;
        strm_mem[0] = MAGIC0;
        strm_mem[1] = MAGIC1;
        strm_mem[2] = MAGIC2;
        strm_mem[3] = MAGIC3;
        strm_mem[4] = (quality < 5) ? 8'd10 : ((quality < 8) ? 8'd22 : 8'd24);
        d = 5;
        sp = 0;
        while (sp < n)
        begin
            if (d + 8 >= cap)
                return 0;
            mlen = longest_run(sp, n, maxlen, back_dist);
            if (mlen != 0)
            begin
                strm_mem[d] = TOK_MATCH;
                strm_mem[d + 1] = back_dist[7:0];
                strm_mem[d + 2] = back_dist[15:8];
                strm_mem[d + 3] = mlen[7:0];
                d += 4;
                sp += mlen;
            end
            else
            begin
                start = sp;
                run = 1;
                sp++;
                while (sp < n && run < 255)
                begin
                    if (longest_run(sp, n, maxlen, back_dist) != 0)
                        break;
                    sp++;
                    run++;
                end
                if (d + run + 2 > cap)
                    return 0;
                strm_mem[d] = TOK_LIT;
                strm_mem[d + 1] = run[7:0];
                for (int unsigned k = 0; k < run; k++)
                    strm_mem[d + 2 + k] = src_mem[start + k];
                d += run + 2;
            end
        end
        if (d + 1 > cap)
            return 0;
        strm_mem[d] = TOK_END;
        return d + 1;
    endfunction

    function automatic bit apply_beat(input logic op, input logic [7:0] data, input logic last,
                                      output rd_beat_t r);
        int unsigned len;
        r = '{8'd0, 1'b0, STAT_EMPTY};
        if (op == OP_LOAD)
        begin
            if (src_cnt == 0)
            begin
                failed = 1'b0;
                strm_len = 0;
                rd_ptr = 0;
            end
            if (src_cnt < SRC_BYTES)
            begin
                src_mem[src_cnt] = data;
                src_cnt++;
            end
            else
                failed = 1'b1;
            if (last)
            begin
                len = failed ? 0 : pack_block(src_cnt);
                strm_len = len;
                rd_ptr = 0;
                failed = (len == 0);
                src_cnt = 0;
            end
            return 1'b0;
        end
        if (failed)
            r.status = STAT_FAIL;
        else if (rd_ptr < strm_len)
        begin
            r.data = strm_mem[rd_ptr];
            r.last = (rd_ptr + 1 == strm_len);
            r.status = STAT_OK;
            rd_ptr++;
        end
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        rd_beat_t pred;
        rd_beat_t want;
        typed_t   tf;
        if (rst_n && s_tvalid && s_tready)
        begin
            tf = typed_q.pop_front();
            if (apply_beat(s_tuser, s_tdata, s_tlast, pred))
                read_q.push_back(tf.fixed ? tf.beat : pred);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (read_q.size() == 0)
            begin
                $display("%0t: unexpected beat data=%h last=%b status=%0d",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end
            else
            begin
                want = read_q.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last || m_tuser !== want.status)
                begin
                    $display("%0t: mismatch expected data=%h last=%b status=%0d, actual data=%h last=%b status=%0d",
                             $time, want.data, want.last, want.status, m_tdata, m_tlast, m_tuser);
                    errors++;
                end
            end
        end
    end

    // receiver: random back-pressure plus long hold-offs on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            m_tready <= calm || ($urandom_range(99) >= 36);
        end
    end

    task automatic send_beat(input logic op, input logic [7:0] data, input logic last,
                             input bit fixed, input rd_beat_t beat);
        while (!calm && $urandom_range(99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        s_tlast <= last;
        typed_q.push_back('{fixed, beat});
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic load(input logic [7:0] data, input logic last);
        send_beat(OP_LOAD, data, last, 1'b0, '{8'd0, 1'b0, STAT_OK});
    endtask

    task automatic read_one();
        send_beat(OP_READ, 8'($urandom), 1'($urandom), 1'b0, '{8'd0, 1'b0, STAT_OK});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (read_q.size() != 0 || typed_q.size() != 0)
            @(posedge clk);
    endtask

    // a trailing read proves any pass is finished before registers move
    task automatic settle();
        drain();
        read_one();
        drain();
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_QUALITY)
            quality = val[3:0];
        else if (idx == REG_CAPACITY)
            capacity = val;
        @(posedge clk);
    endtask

    function automatic void add_beat(input logic op, input logic [7:0] data, input logic last);
        rows.push_back('{1'b0, REG_QUALITY, 15'd0, op, data, last, 1'b0, '{8'd0, 1'b0, STAT_OK}});
    endfunction

    function automatic void add_read(input logic [7:0] data, input logic [1:0] status);
        rows.push_back('{1'b0, REG_QUALITY, 15'd0, OP_READ, 8'hA5, 1'b1, 1'b1,
                         '{data, 1'b0, status}});
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [14:0] val);
        rows.push_back('{1'b1, idx, val, OP_LOAD, 8'd0, 1'b0, 1'b0, '{8'd0, 1'b0, STAT_OK}});
    endfunction

    function automatic logic [7:0] pick_byte(input int style, input int i, input logic [7:0] seed);
        case (style)
            0: return 8'($urandom);
            1: return 8'($urandom_range(3));
            2: return seed + 8'(i % (seed[2:0] + 1));
            default: return seed;
        endcase
    endfunction

    task automatic send_block(input int len, input bit close);
        int style;
        logic [7:0] seed;
        style = $urandom_range(3);
        seed = 8'($urandom);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 3)
                read_one();
            load(pick_byte(style, i, seed), close && (i == len - 1));
        end
    endtask

    initial
    begin
        int sent;
        int len;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        s_tuser = OP_LOAD;
        cfg_we = 1'b0;
        cfg_index = REG_QUALITY;
        cfg_data = 15'd0;
        errors = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        quality = 4'd5;
        capacity = 15'd16384;
        src_cnt = 0;
        strm_len = 0;
        rd_ptr = 0;
        failed = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_read(8'd0, STAT_EMPTY);
        add_cfg(REG_QUALITY, 15'h7FF0);
        add_cfg(REG_CAPACITY, 15'h7FFF);
        add_cfg(2'd2, 15'd4);
        add_cfg(2'd3, 15'd0);
        for (int i = 0; i < 6; i++)
            add_beat(OP_LOAD, i[0] ? 8'hFF : 8'h00, i == 5);
        add_read(MAGIC0, STAT_OK);
        add_read(MAGIC1, STAT_OK);
        add_read(MAGIC2, STAT_OK);
        add_read(MAGIC3, STAT_OK);
        add_read(8'd10, STAT_OK);
        for (int i = 0; i < 9; i++)
            add_beat(OP_READ, 8'h00, 1'b0);
        add_read(8'd0, STAT_EMPTY);
        add_cfg(REG_CAPACITY, 15'd4);
        add_beat(OP_LOAD, 8'h55, 1'b1);
        add_read(8'd0, STAT_FAIL);
        add_cfg(REG_QUALITY, 15'd15);
        add_cfg(REG_CAPACITY, 15'd5);
        add_beat(OP_LOAD, 8'hAA, 1'b1);
        add_read(8'd0, STAT_FAIL);
        add_cfg(REG_CAPACITY, 15'd0);
        add_beat(OP_LOAD, 8'h12, 1'b1);
        add_read(8'd0, STAT_FAIL);

        foreach (rows[r])
        begin
            if (rows[r].is_cfg)
            begin
                settle();
                write_reg(rows[r].idx, rows[r].val);
            end
            else
                send_beat(rows[r].op, rows[r].data, rows[r].last, rows[r].fixed, rows[r].beat);
        end

        // fill the source store, then overflow it on the closing beat
        settle();
        write_reg(REG_CAPACITY, 15'd16384);
        calm = 1'b1;
        for (int i = 0; i < SRC_BYTES; i++)
            load(8'($urandom), 1'b0);
        send_beat(OP_LOAD, 8'h77, 1'b1, 1'b0, '{8'd0, 1'b0, STAT_OK});
        send_beat(OP_READ, 8'h00, 1'b0, 1'b1, '{8'd0, 1'b0, STAT_FAIL});
        calm = 1'b0;

        // long literal runs and longest matches at quality 9, which allows 64-byte matches
        settle();
        write_reg(REG_QUALITY, 15'd9);
        for (int i = 0; i < 300; i++)
            load(8'(i * 7 + (i >> 5)), i == 299);
        repeat (312) read_one();
        for (int i = 0; i < 100; i++)
            load(8'h3C, i == 99);
        repeat (16) read_one();

        // sender holds until all results are in
        drain();
        sent = 0;
        while (sent < 450)
        begin
            if ($urandom_range(3) == 0)
            begin
                settle();
                write_reg(REG_QUALITY, 15'($urandom_range(15)));
                case ($urandom_range(3))
                    0: write_reg(REG_CAPACITY, 15'($urandom_range(80)));
                    1: write_reg(REG_CAPACITY, 15'd16384);
                    2: write_reg(REG_CAPACITY, 15'h7FFF);
                    default: write_reg(REG_CAPACITY, 15'($urandom));
                endcase
            end
            if (sent > 150 && sent < 260)
                calm = 1'b1;
            else
                calm = 1'b0;
            if (sent > 300 && sent < 340)
                hold_req = 1'b1;
            len = $urandom_range(1, 48);
            send_block(len, $urandom_range(9) != 0);
            sent += len;
            repeat ((len * 3) / 4 + $urandom_range(4, 12))
            begin
                read_one();
                sent++;
            end
        end
        calm = 1'b0;
        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== lz_block_compressor.f =====
+incdir+src
src/lzc_pkg.sv
src/lzc_front.sv
src/lzc_engine.sv
src/lz_block_compressor.sv
bench/tb_top.sv
